@@ design/dwi_baseline_normalizer_core_defines.svh @@
// ----------------------------------------------------------------------------
// dwi baseline normaliser assertion macros
// concurrent check wrappers, empty when synthesising
// ----------------------------------------------------------------------------
`ifndef DWI_BASELINE_NORMALIZER_CORE_DEFINES_SVH
`define DWI_BASELINE_NORMALIZER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define DWBN_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dwbn same-cycle check failed");
// next-cycle implication
`define DWBN_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dwbn next-cycle check failed");
`else
`define DWBN_ASSERT_IMP(label, clk, rst, ante, cons)
`define DWBN_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

@@ design/dwbn_pkg.sv @@
// ----------------------------------------------------------------------------
// dwbn_pkg
// shared constants and types of the dwi baseline normaliser
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dwbn_pkg;

  localparam int MAX_GRADIENTS_DEF = 64;
  localparam int SAMPLE_BITS_DEF   = 16;

  localparam int SAMPLE_PORT_W = 16;
  localparam int IN_TDATA_W    = 16;
  localparam int RATIO_W       = 20;
  localparam int FRAC_W        = 16;
  localparam int INT_W         = RATIO_W - FRAC_W;
  localparam int INDEX_W       = 6;
  localparam int OUT_TDATA_W   = 32;
  localparam int MAX_RESULTS   = 63;
  localparam int GCOUNT_W      = 7;
  localparam int MASK_W        = 64;
  localparam int CFG_ADDR_W    = 1;

  localparam logic [CFG_ADDR_W-1:0] REG_GRADIENT_COUNT = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_BASELINE_MASK  = 1'b1;

  localparam logic [GCOUNT_W-1:0] GCOUNT_RESET = 7'd64;
  localparam logic [MASK_W-1:0]   MASK_RESET   = 64'd1;

  // divider status towards the sequencer
  typedef struct packed {
    logic done;
    logic zero;
  } div_res_t;

endpackage

@@ design/dwi_baseline_normalizer_core.sv @@
// ----------------------------------------------------------------------------
// dwi_baseline_normalizer_core
// loading: one sample item per cycle; after the last sample each non-baseline
//   direction passes scan, read, multiply, check, 20 divide steps (none if the
//   sum is zero or the ratio saturates) and emit; each skipped baseline adds a scan
//   step; results are paced by the single one-bit-per-cycle divider and by m_tready
// reset: synchronous, count 64, mask 1, voxel restarts, store contents undefined
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "dwi_baseline_normalizer_core_defines.svh"

module dwi_baseline_normalizer_core #(
  parameter int MAX_GRADIENTS = dwbn_pkg::MAX_GRADIENTS_DEF,
  parameter int SAMPLE_BITS   = dwbn_pkg::SAMPLE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // input items
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [dwbn_pkg::IN_TDATA_W-1:0]  s_tdata,   // [15:0] sample
  // result items
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [dwbn_pkg::OUT_TDATA_W-1:0] m_tdata,   // [19:0] ratio, [25:20] out_index
  output logic                             m_tuser,   // [0] baseline_zero
  output logic                             m_tlast,   // last result of the voxel
  // configuration writes
  input  logic                             cfg_wr_en,
  input  logic [dwbn_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [dwbn_pkg::MASK_W-1:0]      cfg_wdata
);

  // stored sample width: the port carries at most 16 bits
  localparam int SW    = (SAMPLE_BITS < dwbn_pkg::SAMPLE_PORT_W) ?
                         SAMPLE_BITS : dwbn_pkg::SAMPLE_PORT_W;
  localparam int AW    = $clog2(MAX_GRADIENTS);
  localparam int CW    = $clog2(MAX_GRADIENTS + 1);
  localparam int SUM_W = SW + AW;

  typedef enum logic [4:0] {
    S_LOAD = 5'b00001,
    S_SCAN = 5'b00010,
    S_READ = 5'b00100,
    S_DIV  = 5'b01000,
    S_EMIT = 5'b10000
  } state_t;

  state_t state;

  // configuration
  logic [dwbn_pkg::GCOUNT_W-1:0] gcount;
  logic [dwbn_pkg::MASK_W-1:0]   bmask;
  logic [CW-1:0]                 count_eff;

  // voxel state
  logic [CW-1:0]                 pos;
  logic [SUM_W-1:0]              bsum;
  logic [CW-1:0]                 zcount;
  logic [AW-1:0]                 scan_idx;
  logic [dwbn_pkg::INDEX_W-1:0]  out_n;

  // sample store, one read port and one write port
  logic [SW-1:0]                 store [MAX_GRADIENTS];
  logic [SW-1:0]                 rdata;

  logic                          in_acc;
  logic                          out_free;
  logic [AW-1:0]                 waddr;
  logic [SW-1:0]                 sample_val;
  logic                          wbase;
  logic [dwbn_pkg::GCOUNT_W-1:0] tot_raw;
  logic [dwbn_pkg::INDEX_W-1:0]  total;

  dwbn_pkg::div_res_t            div_res;
  logic [dwbn_pkg::RATIO_W-1:0]  div_q;
  logic                          div_start;

  // clamp the configured count to 2..MAX_GRADIENTS
  always_comb begin
    if (gcount < dwbn_pkg::GCOUNT_W'(2)) begin
      count_eff = CW'(2);
    end else if (gcount > dwbn_pkg::GCOUNT_W'(MAX_GRADIENTS)) begin
      count_eff = CW'(MAX_GRADIENTS);
    end else begin
      count_eff = CW'(gcount);
    end
  end

  assign in_acc     = s_tvalid && s_tready;
  assign s_tready   = (state == S_LOAD);
  assign out_free   = !m_tvalid || m_tready;
  assign waddr      = pos[AW-1:0];
  assign sample_val = s_tdata[SW-1:0];
  assign wbase      = bmask[waddr];
  assign div_start  = (state == S_READ);

  // results per voxel: non-baseline directions, capped at 63
  assign tot_raw = dwbn_pkg::GCOUNT_W'(count_eff) - dwbn_pkg::GCOUNT_W'(zcount);
  assign total   = (tot_raw > dwbn_pkg::GCOUNT_W'(dwbn_pkg::MAX_RESULTS)) ?
                   dwbn_pkg::INDEX_W'(dwbn_pkg::MAX_RESULTS) :
                   dwbn_pkg::INDEX_W'(tot_raw);

  // store: written while loading, read continuously at the scan index
  always_ff @(posedge clk) begin
    if (in_acc) begin
      store[waddr] <= sample_val;
    end
    rdata <= store[scan_idx];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gcount <= dwbn_pkg::GCOUNT_RESET;
      bmask  <= dwbn_pkg::MASK_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        dwbn_pkg::REG_GRADIENT_COUNT: gcount <= cfg_wdata[dwbn_pkg::GCOUNT_W-1:0];
        dwbn_pkg::REG_BASELINE_MASK:  bmask  <= cfg_wdata;
        default:                      bmask  <= bmask;
      endcase
    end
  end

  // voxel sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_LOAD;
      pos      <= '0;
      bsum     <= '0;
      zcount   <= '0;
      scan_idx <= '0;
      out_n    <= '0;
    end else if (cfg_wr_en) begin
      // any register write restarts the voxel
      state  <= S_LOAD;
      pos    <= '0;
      bsum   <= '0;
      zcount <= '0;
    end else begin
      unique case (state)
        S_LOAD: begin
          if (in_acc) begin
            if (wbase) begin
              bsum   <= bsum + SUM_W'(sample_val);
              zcount <= zcount + CW'(1);
            end
            if (pos + CW'(1) == count_eff) begin
              pos      <= '0;
              scan_idx <= '0;
              out_n    <= '0;
              state    <= S_SCAN;
            end else begin
              pos <= pos + CW'(1);
            end
          end
        end
        S_SCAN: begin
          if (out_n == total) begin
            // voxel complete
            bsum   <= '0;
            zcount <= '0;
            state  <= S_LOAD;
          end else if (bmask[scan_idx]) begin
            scan_idx <= scan_idx + AW'(1);
          end else begin
            state <= S_READ;
          end
        end
        S_READ: begin
          // store data for scan_idx is valid now, divider starts
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_res.done) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_n    <= out_n + dwbn_pkg::INDEX_W'(1);
            scan_idx <= scan_idx + AW'(1);
            state    <= S_SCAN;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  // output register, frees the sequencer while a result waits
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_EMIT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && out_free) begin
      m_tdata <= dwbn_pkg::OUT_TDATA_W'({out_n, div_q});
      m_tuser <= div_res.zero;
      m_tlast <= (out_n + dwbn_pkg::INDEX_W'(1) == total);
    end
  end

  dwbn_divider #(
    .SAMPLE_W (SW),
    .CNT_W    (CW),
    .SUM_W    (SUM_W)
  ) u_divider (
    .clk        (clk),
    .rst        (rst),
    .start      (div_start),
    .value      (rdata),
    .zero_count (zcount),
    .sum        (bsum),
    .res        (div_res),
    .quotient   (div_q)
  );

  // checks
  `DWBN_ASSERT_IMP(a_done_only_waiting, clk, rst, div_res.done, state == S_DIV)
  `DWBN_ASSERT_IMP(a_load_pos_in_range, clk, rst, state == S_LOAD, pos < count_eff)
  `DWBN_ASSERT_IMP(a_zc_le_pos, clk, rst, state == S_LOAD, zcount <= pos)
  `DWBN_ASSERT_NEXT(a_emit_fills_out, clk, rst, state == S_EMIT && out_free && !cfg_wr_en, m_tvalid)

endmodule

@@ design/dwbn_divider.sv @@
// ----------------------------------------------------------------------------
// dwbn_divider
// scale by baseline count, then radix-2 restoring divide by the baseline sum
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dwbn_divider #(
  parameter int SAMPLE_W = dwbn_pkg::SAMPLE_BITS_DEF,
  parameter int CNT_W    = 7,
  parameter int SUM_W    = 22
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [SAMPLE_W-1:0]          value,
  input  logic [CNT_W-1:0]             zero_count,
  input  logic [SUM_W-1:0]             sum,
  output dwbn_pkg::div_res_t           res,
  output logic [dwbn_pkg::RATIO_W-1:0] quotient
);

  localparam int PROD_W = SAMPLE_W + CNT_W;
  localparam int CMP_W  = (PROD_W > SUM_W + dwbn_pkg::INT_W) ?
                          PROD_W : SUM_W + dwbn_pkg::INT_W;
  localparam int STEP_W = $clog2(dwbn_pkg::RATIO_W + 1);

  typedef enum logic [2:0] {
    D_IDLE  = 3'b001,
    D_CHECK = 3'b010,
    D_RUN   = 3'b100
  } dstate_t;

  dstate_t                     dstate;
  logic [PROD_W-1:0]           prod;
  logic [SUM_W-1:0]            rem;
  logic [dwbn_pkg::RATIO_W-1:0] low;
  logic [STEP_W-1:0]           steps;
  logic                        done;
  logic                        zero;

  logic [CMP_W-1:0] prod_x;
  logic [CMP_W-1:0] limit_x;
  logic [SUM_W:0]   trial;
  logic [SUM_W:0]   diff;
  logic             fits;

  assign prod_x  = CMP_W'(prod);
  assign limit_x = CMP_W'(sum) << dwbn_pkg::INT_W;
  assign trial   = {rem, low[dwbn_pkg::RATIO_W-1]};
  assign fits    = trial >= {1'b0, sum};
  assign diff    = trial - {1'b0, sum};

  always_ff @(posedge clk) begin
    if (rst) begin
      dstate <= D_IDLE;
      done   <= 1'b0;
    end else begin
      unique case (dstate)
        D_IDLE: begin
          done <= 1'b0;
          if (start) begin
            prod   <= PROD_W'(value) * PROD_W'(zero_count);
            dstate <= D_CHECK;
          end
        end
        D_CHECK: begin
          if (sum == '0) begin
            // no baseline signal: flag and force zero
            quotient <= '0;
            zero     <= 1'b1;
            done     <= 1'b1;
            dstate   <= D_IDLE;
          end else if (prod_x >= limit_x) begin
            // quotient would not fit in q4.16
            quotient <= '1;
            zero     <= 1'b0;
            done     <= 1'b1;
            dstate   <= D_IDLE;
          end else begin
            rem    <= SUM_W'(prod_x >> dwbn_pkg::INT_W);
            low    <= {prod[dwbn_pkg::INT_W-1:0], dwbn_pkg::FRAC_W'(0)};
            steps  <= STEP_W'(dwbn_pkg::RATIO_W);
            zero   <= 1'b0;
            done   <= 1'b0;
            dstate <= D_RUN;
          end
        end
        D_RUN: begin
          rem      <= fits ? SUM_W'(diff) : SUM_W'(trial);
          low      <= low << 1;
          quotient <= {quotient[dwbn_pkg::RATIO_W-2:0], fits};
          steps    <= steps - STEP_W'(1);
          done     <= (steps == STEP_W'(1));
          if (steps == STEP_W'(1)) begin
            dstate <= D_IDLE;
          end
        end
        default: begin
          done   <= 1'b0;
          dstate <= D_IDLE;
        end
      endcase
    end
  end

  assign res.done = done;
  assign res.zero = zero;

endmodule

@@ bench/dwbn_ratio_checker.sv @@
// ----------------------------------------------------------------------------
// dwbn_ratio_checker
// watches the sample, result and register channels of the baseline
// normaliser, predicts each voxel's ratio items and compares them in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dwbn_ratio_checker
  import dwbn_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // [15:0] sample
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic [OUT_TDATA_W-1:0] m_tdata,   // [19:0] ratio, [25:20] out_index
  input  logic                   m_tuser,   // [0] baseline_zero
  input  logic                   m_tlast,
  input  logic                   cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [MASK_W-1:0]      cfg_wdata,
  output int unsigned            fail_count,
  output int unsigned            pending_count,
  output int unsigned            results_checked,
  output int unsigned            voxels_done
);

  localparam logic [63:0] RATIO_CEIL = (64'd1 << RATIO_W) - 64'd1;

  typedef struct packed {
    logic [RATIO_W-1:0] ratio;
    logic               base_zero;
    logic [INDEX_W-1:0] index;
    logic               last;
  } norm_result_t;

  logic [SAMPLE_PORT_W-1:0] voxel_samples [MAX_GRADIENTS_DEF];
  logic [21:0]              base_acc;
  int unsigned              load_pos;
  logic [GCOUNT_W-1:0]      grad_count_reg;
  logic [MASK_W-1:0]        base_mask_reg;
  norm_result_t             ratio_q [$];

  function automatic int unsigned voxel_span();
    int unsigned c;
    c = grad_count_reg;
    if (c < 2) c = 2;
    if (c > MAX_GRADIENTS_DEF) c = MAX_GRADIENTS_DEF;
    return c;
  endfunction

  // store one sample; on the voxel's last one queue every ratio it yields
  task automatic absorb_sample(input logic [SAMPLE_PORT_W-1:0] smp);
    int unsigned  span;
    int unsigned  pos;
    int unsigned  base_n;
    int unsigned  other_n;
    int unsigned  n;
    logic [63:0]  quot;
    norm_result_t r;
    span = voxel_span();
    pos = load_pos;
    if (pos >= span) pos = 0;
    voxel_samples[pos] = smp;
    if (base_mask_reg[pos]) base_acc = base_acc + smp;
    pos++;
    if (pos < span) begin
      load_pos = pos;
      return;
    end
    base_n = 0;
    other_n = 0;
    for (int i = 0; i < span; i++) begin
      if (base_mask_reg[i]) base_n++;
      else other_n++;
    end
    if (other_n > MAX_RESULTS) other_n = MAX_RESULTS;
    n = 0;
    for (int i = 0; i < span && n < other_n; i++) begin
      if (!base_mask_reg[i]) begin
        r = '0;
        if (base_acc == '0) begin
          r.base_zero = 1'b1;
        end else begin
          quot = ((64'(voxel_samples[i]) * 64'(base_n)) << FRAC_W) / 64'(base_acc);
          r.ratio = (quot > RATIO_CEIL) ? RATIO_CEIL[RATIO_W-1:0] : quot[RATIO_W-1:0];
        end
        r.index = INDEX_W'(n);
        r.last  = (n + 1 == other_n);
        ratio_q.insert(ratio_q.size(), r);
        n++;
      end
    end
    load_pos = 0;
    base_acc = '0;
    voxels_done++;
  endtask

  task automatic check_result();
    norm_result_t got;
    norm_result_t want;
    got.ratio     = m_tdata[RATIO_W-1:0];
    got.index     = m_tdata[RATIO_W +: INDEX_W];
    got.base_zero = m_tuser;
    got.last      = m_tlast;
    results_checked++;
    if (ratio_q.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("%0t: unexpected result: ratio %h zero %b index %0d last %b",
                 $realtime, got.ratio, got.base_zero, got.index, got.last);
    end else begin
      want = ratio_q.pop_front();
      if (got.ratio !== want.ratio || got.base_zero !== want.base_zero ||
          got.index !== want.index || got.last !== want.last) begin
        fail_count++;
        if (fail_count <= 10)
          $display("%0t: result mismatch: expected ratio %h zero %b index %0d last %b, got ratio %h zero %b index %0d last %b",
                   $realtime, want.ratio, want.base_zero, want.index, want.last,
                   got.ratio, got.base_zero, got.index, got.last);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      grad_count_reg = GCOUNT_RESET;
      base_mask_reg  = MASK_RESET;
      load_pos       = 0;
      base_acc       = '0;
      ratio_q.delete();
    end else begin
      // any register write restarts the voxel
      if (cfg_wr_en) begin
        if (cfg_addr == REG_GRADIENT_COUNT) grad_count_reg = cfg_wdata[GCOUNT_W-1:0];
        else base_mask_reg = cfg_wdata;
        load_pos = 0;
        base_acc = '0;
      end
      if (s_tvalid && s_tready) absorb_sample(s_tdata[SAMPLE_PORT_W-1:0]);
      if (m_tvalid && m_tready) check_result();
    end
    pending_count = ratio_q.size();
  end

endmodule

@@ bench/tb_dwi_baseline_normalizer_core.sv @@
// ----------------------------------------------------------------------------
// tb_dwi_baseline_normalizer_core
// drives voxels of raw samples under a range of gradient counts and baseline
// masks, with random idling on both streams; a separate checker predicts and
// compares every ratio item
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_dwi_baseline_normalizer_core;
  import dwbn_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 200;     // covers the longest scan with no item out
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned RANDOM_ITEMS  = 230;
  localparam int unsigned QUIET_TAIL    = 40;      // final items with no idling

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata   = '0;       // [15:0] sample
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;              // [19:0] ratio, [25:20] out_index
  logic                   m_tuser;              // [0] baseline_zero
  logic                   m_tlast;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr  = '0;
  logic [MASK_W-1:0]      cfg_wdata = '0;

  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned results_checked;
  int unsigned voxels_done;
  int unsigned cycle_count = 0;
  int unsigned items_sent  = 0;
  int unsigned stall_odds  = 0;   // result side: 0 means never stall
  int unsigned stall_left  = 0;
  int unsigned gap_odds    = 0;   // sample side: 0 means never idle

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  dwi_baseline_normalizer_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  dwbn_ratio_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .m_tuser         (m_tuser),
    .m_tlast         (m_tlast),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_addr        (cfg_addr),
    .cfg_wdata       (cfg_wdata),
    .fail_count      (fail_count),
    .pending_count   (pending_count),
    .results_checked (results_checked),
    .voxels_done     (voxels_done)
  );

  // watchdog
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d results still awaited", cycle_count, pending_count);
    $display("CHECK FAILED");
    $finish;
  end

  // result-side back-pressure: random bursts with tready held low
  always @(posedge clk) begin
    if (stall_left > 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!rst && stall_odds != 0 && $urandom_range(0, stall_odds - 1) == 0) begin
      m_tready   <= 1'b0;
      stall_left <= $urandom_range(0, 18);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // one register write, then the enable drops for a cycle
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [MASK_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // count goes out with random upper bits, which the block must drop
  task automatic set_voxel_shape(input logic [GCOUNT_W-1:0] count, input logic [MASK_W-1:0] mask);
    logic [MASK_W-1:0] word;
    word = {$urandom, $urandom};
    word[GCOUNT_W-1:0] = count;
    write_reg(REG_GRADIENT_COUNT, word);
    write_reg(REG_BASELINE_MASK, mask);
  endtask

  // present one sample item, optionally after an idle burst, and wait for it
  // to be taken; tready is read at the falling edge where it is stable
  task automatic push_sample(input logic [SAMPLE_PORT_W-1:0] smp);
    logic took;
    if (gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= smp;
    do begin
      @(negedge clk);
      took = s_tready;
      @(posedge clk);
    end while (!took);
    items_sent++;
  endtask

  // stop sending, wait for every predicted item, then let trailing
  // baseline scans finish before anything is reconfigured
  task automatic finish_phase();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (pending_count != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // weighted towards the edges: zero, full scale, tiny baselines
  function automatic logic [SAMPLE_PORT_W-1:0] pick_sample();
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return '1;
      2:       return SAMPLE_PORT_W'($urandom_range(1, 8));
      3:       return SAMPLE_PORT_W'($urandom) | 16'h8000;
      default: return SAMPLE_PORT_W'($urandom);
    endcase
  endfunction

  function automatic logic [MASK_W-1:0] pick_mask(input int unsigned span);
    case ($urandom_range(0, 7))
      0:       return {$urandom, $urandom};
      1:       return 64'd1 << $urandom_range(0, span - 1);
      2:       return '1;
      3:       return '0;
      4:       return {$urandom, $urandom} & {$urandom, $urandom};
      5:       return 64'd1;
      6:       return ~(64'd1 << $urandom_range(0, span - 1));
      default: return {$urandom, $urandom} | {$urandom, $urandom};
    endcase
  endfunction

  initial begin
    int unsigned         phase;
    int unsigned         span;
    int unsigned         voxels;
    int unsigned         directed_items;
    logic [GCOUNT_W-1:0] count_word;
    logic [MASK_W-1:0]   mask;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- directed voxels ----
    gap_odds   = 4;
    stall_odds <= 6;

    // single baseline of 1: full-scale sample saturates, zero gives zero,
    // equal sample gives exactly 1.0
    set_voxel_shape(7'd4, 64'b0001);
    push_sample(16'd1);
    push_sample(16'hFFFF);
    push_sample(16'd0);
    push_sample(16'd1);
    finish_phase();

    // baselines all zero: flagged zero-sum results
    set_voxel_shape(7'd3, 64'b011);
    push_sample(16'd0);
    push_sample(16'd0);
    push_sample(16'd123);
    finish_phase();

    // count below range clamps to two; every direction a baseline, no item out
    set_voxel_shape(7'd0, 64'b11);
    push_sample(16'd5);
    push_sample(16'd7);
    finish_phase();

    // mask bits only beyond the count: no baseline at all
    set_voxel_shape(7'd3, 64'hFFFF_FFFF_FFFF_FFF8);
    push_sample(16'hFFFF);
    push_sample(16'd1);
    push_sample(16'd2);
    finish_phase();

    // two large baselines, mean near full scale
    set_voxel_shape(7'd4, 64'b0101);
    push_sample(16'hFFFF);
    push_sample(16'd40000);
    push_sample(16'hFFFF);
    push_sample(16'h8000);
    finish_phase();

    // half a voxel, then a register write restarts it
    set_voxel_shape(7'd5, 64'b1);
    push_sample(16'd9);
    push_sample(16'd10);
    finish_phase();
    set_voxel_shape(7'd1, 64'b1);
    push_sample(16'd100);
    push_sample(16'd300);
    finish_phase();

    directed_items = items_sent;

    // ---- random phases ----
    phase = 0;
    while (items_sent < directed_items + RANDOM_ITEMS) begin
      phase++;
      if (directed_items + RANDOM_ITEMS - items_sent <= QUIET_TAIL) begin
        gap_odds   = 0;
        stall_odds <= 0;
      end else begin
        gap_odds   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 8);
        stall_odds <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 8);
      end

      case ($urandom_range(0, 29))
        0:       count_word = GCOUNT_W'($urandom_range(0, 1));
        1:       count_word = GCOUNT_W'($urandom_range(64, 127));
        2, 3:    count_word = GCOUNT_W'($urandom_range(24, 40));
        default: count_word = GCOUNT_W'($urandom_range(2, 10));
      endcase
      // first random phase: more non-baseline directions than can be emitted
      if (phase == 1) count_word = 7'd100;
      span = count_word;
      if (span < 2) span = 2;
      if (span > MAX_GRADIENTS_DEF) span = MAX_GRADIENTS_DEF;
      mask = (phase == 1) ? '0 : pick_mask(span);

      set_voxel_shape(count_word, mask);
      voxels = (span > 16) ? 1 : $urandom_range(1, 5);
      repeat (voxels) begin
        repeat (span) push_sample(pick_sample());
      end
      // sometimes leave a voxel half loaded for the next write to abandon
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, span - 1)) push_sample(pick_sample());
      end
      finish_phase();
    end

    $display("%0d sample items in %0d random phases after %0d directed items, %0d voxels completed",
             items_sent, phase, directed_items, voxels_done);
    $display("%0d ratio items checked, %0d mismatches, %0d still awaited",
             results_checked, fail_count, pending_count);
    if (fail_count == 0 && pending_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

@@ dwi_baseline_normalizer_core.f @@
+incdir+design
design/dwbn_pkg.sv
design/dwbn_divider.sv
design/dwi_baseline_normalizer_core.sv
bench/dwbn_ratio_checker.sv
bench/tb_dwi_baseline_normalizer_core.sv
